// ===== sv/rti_pkg.sv =====
// Shared types, constants and the step table of the ray-triangle intersection block.
package rti_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int EPS_BITS       = 41;
	localparam logic [EPS_BITS-1:0] EPS_RESET = 41'd1678;
	localparam int FRAC_BITS      = 32;

	// Configuration register indexes.
	localparam logic CFG_TWO_SIDED   = 1'b0;
	localparam logic CFG_DET_EPSILON = 1'b1;

	// Number of multiply-accumulate steps in one test, and the last step.
	localparam int STEP_COUNT = 24;
	localparam logic [4:0] STEP_LAST = 5'(STEP_COUNT - 1);

	// Vectors that feed the narrow operand of the multiplier.
	localparam logic [1:0] VA_D  = 2'd0;
	localparam logic [1:0] VA_E1 = 2'd1;
	localparam logic [1:0] VA_E2 = 2'd2;
	localparam logic [1:0] VA_T  = 2'd3;

	// Vectors that feed the wide operand of the multiplier.
	localparam logic [1:0] VB_E1 = 2'd0;
	localparam logic [1:0] VB_E2 = 2'd1;
	localparam logic [1:0] VB_P  = 2'd2;
	localparam logic [1:0] VB_Q  = 2'd3;

	// Where the accumulator lands at the end of a step.
	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_P    = 3'd1;
	localparam logic [2:0] DST_Q    = 3'd2;
	localparam logic [2:0] DST_DET  = 3'd3;
	localparam logic [2:0] DST_U    = 3'd4;
	localparam logic [2:0] DST_V    = 3'd5;
	localparam logic [2:0] DST_T    = 3'd6;

	typedef struct packed {
		logic first;
		logic sub;
	} mac_ctl_t;

	typedef struct packed {
		logic [1:0] a_vec;
		logic [1:0] a_comp;
		logic [1:0] b_vec;
		logic [1:0] b_comp;
		mac_ctl_t   ctl;
		logic [2:0] dst;
		logic [1:0] dst_comp;
	} step_t;

	function automatic step_t mk(input logic [1:0] av, input logic [1:0] ac,
			input logic [1:0] bv, input logic [1:0] bc, input logic first,
			input logic sub, input logic [2:0] dst, input logic [1:0] dc);
		step_t s;
		s.a_vec    = av;
		s.a_comp   = ac;
		s.b_vec    = bv;
		s.b_comp   = bc;
		s.ctl.first = first;
		s.ctl.sub  = sub;
		s.dst      = dst;
		s.dst_comp = dc;
		return s;
	endfunction

	// p = dir x e2, det = e1.p, q = t x e1, U = t.p, V = dir.q, T = e2.q
	function automatic step_t step_decode(input logic [4:0] step);
		step_t s;
		case (step)
			5'd0:  s = mk(VA_D,  2'd1, VB_E2, 2'd2, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd1:  s = mk(VA_D,  2'd2, VB_E2, 2'd1, 1'b0, 1'b1, DST_P,    2'd0);
			5'd2:  s = mk(VA_D,  2'd2, VB_E2, 2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd3:  s = mk(VA_D,  2'd0, VB_E2, 2'd2, 1'b0, 1'b1, DST_P,    2'd1);
			5'd4:  s = mk(VA_D,  2'd0, VB_E2, 2'd1, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd5:  s = mk(VA_D,  2'd1, VB_E2, 2'd0, 1'b0, 1'b1, DST_P,    2'd2);
			5'd6:  s = mk(VA_E1, 2'd0, VB_P,  2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd7:  s = mk(VA_E1, 2'd1, VB_P,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
			5'd8:  s = mk(VA_E1, 2'd2, VB_P,  2'd2, 1'b0, 1'b0, DST_DET,  2'd0);
			5'd9:  s = mk(VA_T,  2'd1, VB_E1, 2'd2, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd10: s = mk(VA_T,  2'd2, VB_E1, 2'd1, 1'b0, 1'b1, DST_Q,    2'd0);
			5'd11: s = mk(VA_T,  2'd2, VB_E1, 2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd12: s = mk(VA_T,  2'd0, VB_E1, 2'd2, 1'b0, 1'b1, DST_Q,    2'd1);
			5'd13: s = mk(VA_T,  2'd0, VB_E1, 2'd1, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd14: s = mk(VA_T,  2'd1, VB_E1, 2'd0, 1'b0, 1'b1, DST_Q,    2'd2);
			5'd15: s = mk(VA_T,  2'd0, VB_P,  2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd16: s = mk(VA_T,  2'd1, VB_P,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
			5'd17: s = mk(VA_T,  2'd2, VB_P,  2'd2, 1'b0, 1'b0, DST_U,    2'd0);
			5'd18: s = mk(VA_D,  2'd0, VB_Q,  2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd19: s = mk(VA_D,  2'd1, VB_Q,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
			5'd20: s = mk(VA_D,  2'd2, VB_Q,  2'd2, 1'b0, 1'b0, DST_V,    2'd0);
			5'd21: s = mk(VA_E2, 2'd0, VB_Q,  2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
			5'd22: s = mk(VA_E2, 2'd1, VB_Q,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
			5'd23: s = mk(VA_E2, 2'd2, VB_Q,  2'd2, 1'b0, 1'b0, DST_T,    2'd0);
			default: s = mk(VA_D, 2'd0, VB_E1, 2'd0, 1'b1, 1'b0, DST_NONE, 2'd0);
		endcase
		return s;
	endfunction

endpackage

// ===== sv/rti_mac.sv =====
// Shared multiply-accumulate unit used for every cross and dot product.
module rti_mac #(
	parameter int DW = 17,
	parameter int XW = 35,
	parameter int AW = 54
) (
	input  logic                 clk,
	input  logic                 en,
	input  rti_pkg::mac_ctl_t    ctl,
	input  logic signed [DW-1:0] a,
	input  logic signed [XW-1:0] b,
	output logic signed [AW-1:0] acc_next
);

	logic signed [DW+XW-1:0] prod;
	logic signed [AW-1:0]    base;
	logic signed [AW-1:0]    acc_q;

	assign prod = a * b;
	assign base = ctl.first ? '0 : acc_q;
	assign acc_next = ctl.sub ? base - AW'(prod) : base + AW'(prod);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_next;
		end
	end

endmodule

// ===== sv/rti_div.sv =====
// Radix-2 restoring divider that forms the saturated Q16.16 ray fraction.
module rti_div #(
	parameter int AW = 54
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          neg,
	input  logic [AW-1:0] mag,
	input  logic [AW-1:0] den,
	output logic          done,
	output logic [rti_pkg::FRAC_BITS-1:0] frac
);

	localparam int FB = rti_pkg::FRAC_BITS;

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [AW-1:0] rem_q;
	logic [AW-1:0] den_q;
	logic [FB-1:0] bits_q;
	logic          sat_q;
	logic          neg_q;
	logic [AW-1:0] trial;
	logic          ge;
	logic          sat_start;
	logic [FB:0]   res;
	logic [FB:0]   lim;

	assign trial = {rem_q[AW-2:0], bits_q[FB-1]};
	assign ge = trial >= den_q;
	// The quotient would reach 2^16 in integer part: the result saturates.
	assign sat_start = {16'b0, mag} >= {den, 16'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(FB - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= mag >> 16;
			bits_q <= {mag[15:0], 16'b0};
			den_q  <= den;
			sat_q  <= sat_start;
			neg_q  <= neg;
		end else if (busy_q) begin
			rem_q  <= ge ? trial - den_q : trial;
			bits_q <= {bits_q[FB-2:0], ge};
		end
	end

	always_comb begin
		res = sat_q ? {1'b1, {FB{1'b0}}} : {1'b0, bits_q};
		if (neg_q) begin
			lim = (res > {2'b01, {(FB-1){1'b0}}}) ? {2'b01, {(FB-1){1'b0}}} : res;
		end else begin
			lim = (res > {2'b00, {(FB-1){1'b1}}}) ? {2'b00, {(FB-1){1'b1}}} : res;
		end
	end

	assign done = done_q;
	assign frac = neg_q ? FB'(-lim) : lim[FB-1:0];

endmodule

// ===== sv/ray_triangle_intersection.sv =====
// Top level of the fixed-point Moller-Trumbore ray-triangle intersection block.
//
// Usage: each input transaction on the s_ channel writes one vector into a
// five-entry store: slots 0 to 2 are the triangle corners, 3 the ray origin and
// 4 the ray direction. A transaction with s_tlast high stores its vector and
// then runs the intersection test; it yields exactly one output transaction on
// the m_ channel carrying the hit flag in m_tuser and the Q16.16 ray fraction in
// m_tdata. Non-final transactions produce no output and keep s_tready high.
// A final transaction first runs the 24 steps of the single shared
// multiply-accumulate unit (one product per cycle for both cross products and
// the four dot products), then the determinant and barycentric checks, then
// on a hit the bit-serial divider (32 quotient bits, then the hand-over of the
// fraction), and last the load of the output register.
// s_tready is low from the acceptance until that load.
// The result sits in an output register; a stalled receiver holds the block
// only once a second result is ready to be written. Reset clears the control
// state and sets the registers to one-sided mode with an epsilon of 1678; the
// vector store is not cleared and every slot must be written before a test
// reads it. The user must make configuration writes through cfg_we at a clock
// edge while idle; the block itself does not enforce this.
module ray_triangle_intersection #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
	localparam int TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [TDATA_W-1:0]  s_tdata,  // coord_x, coord_y, coord_z
	input  logic [7:0]          s_tuser,  // vector_slot
	input  logic                s_tlast,  // final_vector
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,  // ray_fraction
	output logic [7:0]          m_tuser,  // hit
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [rti_pkg::EPS_BITS-1:0] cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;          // edge and offset components
	localparam int XW = 2 * CB + 3;      // cross product components
	localparam int AW = DW + XW + 2;     // dot products
	localparam int CW = AW + rti_pkg::EPS_BITS + 1;
	localparam int FB = rti_pkg::FRAC_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC    = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [4:0] step_q;
	logic       two_sided_q;
	logic [rti_pkg::EPS_BITS-1:0] eps_q;

	// Vector store, written at the slot address and read at fixed entries.
	logic signed [CB-1:0] store_q [5][3];
	logic signed [DW-1:0] dir  [3];
	logic signed [DW-1:0] e1   [3];
	logic signed [DW-1:0] e2   [3];
	logic signed [DW-1:0] tv   [3];
	logic signed [XW-1:0] p_q  [3];
	logic signed [XW-1:0] q_q  [3];
	logic signed [AW-1:0] det_q, u_q, v_q, t_q;

	rti_pkg::step_t       step;
	logic signed [DW-1:0] op_a;
	logic signed [XW-1:0] op_b;
	logic signed [AW-1:0] acc_next;
	logic                 mac_en;

	logic s_fire;
	logic signed [CW-1:0] det_w, eps_w;
	logic det_miss;
	logic det_neg;
	logic signed [AW-1:0] det_n, u_n, v_n, t_n;
	logic signed [AW:0]   uv_sum;
	logic bary_miss;
	logic div_start, div_done;
	logic [AW-1:0] div_mag;
	logic [FB-1:0] div_frac;

	logic          m_tvalid_q;
	logic          hit_q;
	logic [FB-1:0] frac_q;
	logic          res_hit;
	logic [FB-1:0] res_frac;
	logic          res_load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (s_fire && s_tuser[2:0] < 3'd5) begin
			for (int c = 0; c < 3; c++) begin
				store_q[s_tuser[2:0]][c] <= s_tdata[c*CB +: CB];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dir[c] = DW'(store_q[4][c]);
			e1[c]  = DW'(store_q[1][c]) - DW'(store_q[0][c]);
			e2[c]  = DW'(store_q[2][c]) - DW'(store_q[0][c]);
			tv[c]  = DW'(store_q[3][c]) - DW'(store_q[0][c]);
		end
	end

	// Operand selection for the shared multiply-accumulate unit.
	assign step = rti_pkg::step_decode(step_q);

	always_comb begin
		case (step.a_vec)
			rti_pkg::VA_D:  op_a = dir[step.a_comp];
			rti_pkg::VA_E1: op_a = e1[step.a_comp];
			rti_pkg::VA_E2: op_a = e2[step.a_comp];
			rti_pkg::VA_T:  op_a = tv[step.a_comp];
			default:        op_a = '0;
		endcase
		case (step.b_vec)
			rti_pkg::VB_E1: op_b = XW'(e1[step.b_comp]);
			rti_pkg::VB_E2: op_b = XW'(e2[step.b_comp]);
			rti_pkg::VB_P:  op_b = p_q[step.b_comp];
			rti_pkg::VB_Q:  op_b = q_q[step.b_comp];
			default:        op_b = '0;
		endcase
	end

	assign mac_en = (state_q == ST_MAC);

	rti_mac #(.DW(DW), .XW(XW), .AW(AW)) u_mac (
		.clk      (clk),
		.en       (mac_en),
		.ctl      (step.ctl),
		.a        (op_a),
		.b        (op_b),
		.acc_next (acc_next)
	);

	// Results of the finished steps land in their own registers.
	always_ff @(posedge clk) begin
		if (mac_en) begin
			case (step.dst)
				rti_pkg::DST_P:   p_q[step.dst_comp] <= XW'(acc_next);
				rti_pkg::DST_Q:   q_q[step.dst_comp] <= XW'(acc_next);
				rti_pkg::DST_DET: det_q <= acc_next;
				rti_pkg::DST_U:   u_q <= acc_next;
				rti_pkg::DST_V:   v_q <= acc_next;
				rti_pkg::DST_T:   t_q <= acc_next;
				default: ;
			endcase
		end
	end

	// Determinant test: a zero determinant always misses. Two-sided mode
	// rejects small magnitudes, one-sided mode anything below epsilon.
	assign det_w = CW'(det_q);
	assign eps_w = CW'({1'b0, eps_q});
	always_comb begin
		if (det_q == '0) begin
			det_miss = 1'b1;
		end else if (two_sided_q) begin
			det_miss = (det_w > -eps_w) && (det_w < eps_w);
		end else begin
			det_miss = det_w < eps_w;
		end
	end

	// With a negative determinant all terms flip sign, so the barycentric
	// bounds can be checked against det without any division.
	assign det_neg = det_q[AW-1];
	assign det_n = det_neg ? -det_q : det_q;
	assign u_n   = det_neg ? -u_q : u_q;
	assign v_n   = det_neg ? -v_q : v_q;
	assign t_n   = det_neg ? -t_q : t_q;
	assign uv_sum = (AW+1)'(u_n) + (AW+1)'(v_n);
	assign bary_miss = u_n[AW-1] || (u_n > det_n) || v_n[AW-1]
		|| (uv_sum > (AW+1)'(det_n));

	assign div_start = (state_q == ST_CHECK) && !det_miss && !bary_miss;
	assign div_mag = t_n[AW-1] ? AW'(-t_n) : AW'(t_n);

	rti_div #(.AW(AW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.neg    (t_n[AW-1]),
		.mag    (div_mag),
		.den    (AW'(det_n)),
		.done   (div_done),
		.frac   (div_frac)
	);

	// Sequencer and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			two_sided_q <= 1'b0;
			eps_q       <= rti_pkg::EPS_RESET;
			res_hit     <= 1'b0;
			res_frac    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rti_pkg::CFG_TWO_SIDED:   two_sided_q <= cfg_data[0];
					rti_pkg::CFG_DET_EPSILON: eps_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire && s_tlast) begin
						step_q  <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					step_q <= step_q + 5'd1;
					if (step_q == rti_pkg::STEP_LAST) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						res_hit  <= 1'b0;
						res_frac <= '0;
						state_q  <= ST_RESULT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_hit  <= 1'b1;
						res_frac <= div_frac;
						state_q  <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: a new result is written once the previous one is taken.
	assign res_load = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			hit_q  <= res_hit;
			frac_q <= res_frac;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = frac_q;
	assign m_tuser  = {7'b0, hit_q};

endmodule

// ===== sv/rti_checker.sv =====
// Port-level checker for the ray-triangle intersection block, with its bind.
module rti_checker #(
	parameter int TDATA_W = 48
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               s_tlast,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [31:0]        m_tdata,
	input logic [7:0]         m_tuser
);

	// A final transaction starts a test, so the input side stops at once.
	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still ready after a final transaction");

	// A vector that only loads the store keeps the input side open.
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input stalled after a plain load");

	// A miss always reports a zero fraction.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("miss with nonzero fraction");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind ray_triangle_intersection rti_checker #(.TDATA_W(TDATA_W)) u_rti_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
